[rtl/vcr_pkg.sv]
// Package: shared widths, defaults and constants for the voxel collision relocator.
`default_nettype none
package vcr_pkg;
	localparam int ID_W       = 8;
	localparam int POS_W      = 4;
	localparam int CNT_W      = 16;
	localparam int EPOCH_BITS = 4;

	localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(10);

	localparam logic FUNC_FRAME = 1'b0;
	localparam logic FUNC_PLACE = 1'b1;

	localparam int GRID_X_DEF  = 16;
	localparam int GRID_Y_DEF  = 16;
	localparam int GRID_Z_DEF  = 16;
	localparam int ID_BITS_DEF = 8;
endpackage
`default_nettype wire

[rtl/vcr_if.sv]
// Interfaces: request and response channels of the voxel collision relocator.
`default_nettype none
interface vcr_req_if import vcr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic [ID_W-1:0]  drone_id;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic [POS_W-1:0] pos_z;

	modport source (output valid, func, drone_id, pos_x, pos_y, pos_z, input ready);
	modport sink   (input valid, func, drone_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface vcr_rsp_if import vcr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             collided;
	logic [ID_W-1:0]  other_drone;
	logic             relocated;
	logic [POS_W-1:0] placed_x;
	logic [POS_W-1:0] placed_y;
	logic [POS_W-1:0] placed_z;
	logic [CNT_W-1:0] collision_total;
	logic             aborted;
	logic             out_of_range;

	modport source (output valid, collided, other_drone, relocated, placed_x, placed_y,
		placed_z, collision_total, aborted, out_of_range, input ready);
	modport sink   (input valid, collided, other_drone, relocated, placed_x, placed_y,
		placed_z, collision_total, aborted, out_of_range, output ready);
endinterface
`default_nettype wire

[rtl/vcr_ram.sv]
// Grid memory: one write port, one read port, registered read data.
`default_nettype none
module vcr_ram #(
	parameter int AW = 12,
	parameter int DW = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/voxel_collision_relocator.sv]
// Top level: voxel occupancy grid with collision counting and nearest-free-cell relocation.
// One word is taken at a time through a small sequencer around the grid memory. Aborted and
// out-of-grid words, and frame starts that do not wrap the tag, go from accept straight to
// result; a placement without collision runs accept, read, check, result. On a collision
// under the abort limit the search probes one candidate at a time: one outside the grid is skipped,
// one inside is read and then checked, up to 6*(max(GRID_X,GRID_Y,GRID_Z)-1) candidates.
// Cells carry a frame tag so a frame start does not touch the memory; after reset, and on
// every 2**EPOCH_BITS-th frame start when the tag wraps, a clearing pass over all 2**AW
// addresses (4096 at the default 16x16x16 grid) runs with ready low. A new word is accepted
// while the previous result still waits in the output register.
`default_nettype none
module voxel_collision_relocator import vcr_pkg::*; #(
	parameter int GRID_X  = GRID_X_DEF,
	parameter int GRID_Y  = GRID_Y_DEF,
	parameter int GRID_Z  = GRID_Z_DEF,
	parameter int ID_BITS = ID_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_data,
	vcr_req_if.sink               req,
	vcr_rsp_if.source             rsp
);
	localparam int XW    = $clog2(GRID_X);
	localparam int YW    = $clog2(GRID_Y);
	localparam int ZW    = $clog2(GRID_Z);
	localparam int AW    = XW + YW + ZW;
	localparam int DW    = EPOCH_BITS + ID_BITS;
	localparam int MAXR  = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
		: ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
	localparam int RW    = $clog2(MAXR);
	localparam int CW    = ((RW > POS_W) ? RW : POS_W) + 2;

	localparam logic signed [CW-1:0] LIM_X = CW'(GRID_X);
	localparam logic signed [CW-1:0] LIM_Y = CW'(GRID_Y);
	localparam logic signed [CW-1:0] LIM_Z = CW'(GRID_Z);
	localparam logic [RW-1:0] R_LAST = RW'(MAXR - 1);

	localparam logic [2:0] DIR_PX = 3'd0;
	localparam logic [2:0] DIR_NX = 3'd1;
	localparam logic [2:0] DIR_PY = 3'd2;
	localparam logic [2:0] DIR_NY = 3'd3;
	localparam logic [2:0] DIR_PZ = 3'd4;
	localparam logic [2:0] DIR_NZ = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_LOOKUP,
		ST_CHECK,
		ST_PROBE,
		ST_PCHK,
		ST_FINISH
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           sweep_q;
	logic                    sweep_rsp_q;
	logic [EPOCH_BITS-1:0]   epoch_q;
	logic [CNT_W-1:0]        limit_q;
	logic [CNT_W-1:0]        count_q;
	logic                    abort_q;

	logic [POS_W-1:0]        rx_q, ry_q, rz_q;
	logic [ID_BITS-1:0]      id_q;
	logic [2:0]              dir_q;
	logic [RW-1:0]           r_q;
	logic signed [CW-1:0]    cx_q, cy_q, cz_q;

	logic                    collided_q, relocated_q, oor_q;
	logic [ID_W-1:0]         other_q;
	logic [POS_W-1:0]        px_q, py_q, pz_q;

	logic                    ov_q;
	logic                    o_collided_q, o_relocated_q, o_oor_q, o_aborted_q;
	logic [ID_W-1:0]         o_other_q;
	logic [POS_W-1:0]        o_px_q, o_py_q, o_pz_q;
	logic [CNT_W-1:0]        o_total_q;

	logic signed [CW-1:0]    bx, by, bz, rs, cx, cy, cz;
	logic                    cand_in, last_probe;
	logic [AW-1:0]           base_addr, cand_addr, cand_q_addr;
	logic                    mem_we, mem_re;
	logic [AW-1:0]           mem_waddr, mem_raddr;
	logic [DW-1:0]           mem_wdata, mem_rdata;
	logic [EPOCH_BITS-1:0]   rd_epoch;
	logic [ID_BITS-1:0]      rd_id, holder;
	logic [CNT_W-1:0]        count_inc;
	logic [EPOCH_BITS-1:0]   epoch_inc;
	logic                    req_oor, out_free;

	vcr_ram #(
		.AW (AW),
		.DW (DW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign bx = signed'(CW'(rx_q));
	assign by = signed'(CW'(ry_q));
	assign bz = signed'(CW'(rz_q));
	assign rs = signed'(CW'(r_q));

	always_comb begin
		cx = bx;
		cy = by;
		cz = bz;
		case (dir_q)
			DIR_PX:  cx = bx + rs;
			DIR_NX:  cx = bx - rs;
			DIR_PY:  cy = by + rs;
			DIR_NY:  cy = by - rs;
			DIR_PZ:  cz = bz + rs;
			DIR_NZ:  cz = bz - rs;
			default: cx = bx;
		endcase
	end

	assign cand_in = !cx[CW-1] && (cx < LIM_X) && !cy[CW-1] && (cy < LIM_Y)
		&& !cz[CW-1] && (cz < LIM_Z);
	assign last_probe = (dir_q == DIR_NZ) && (r_q == R_LAST);

	assign base_addr   = {bx[XW-1:0], by[YW-1:0], bz[ZW-1:0]};
	assign cand_addr   = {cx[XW-1:0], cy[YW-1:0], cz[ZW-1:0]};
	assign cand_q_addr = {cx_q[XW-1:0], cy_q[YW-1:0], cz_q[ZW-1:0]};

	assign rd_epoch = mem_rdata[DW-1 -: EPOCH_BITS];
	assign rd_id    = mem_rdata[ID_BITS-1:0];
	assign holder   = (rd_epoch == epoch_q) ? rd_id : '0;

	assign count_inc = (count_q == '1) ? count_q : count_q + CNT_W'(1);
	assign epoch_inc = epoch_q + EPOCH_BITS'(1);
	assign req_oor   = (int'(req.pos_x) >= GRID_X) || (int'(req.pos_y) >= GRID_Y)
		|| (int'(req.pos_z) >= GRID_Z);
	assign out_free  = !ov_q || rsp.ready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = base_addr;
		mem_wdata = {epoch_q, id_q};
		mem_re    = 1'b0;
		mem_raddr = base_addr;
		case (state_q)
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = '0;
			end
			ST_LOOKUP: begin
				mem_re = 1'b1;
			end
			ST_CHECK: begin
				mem_we = (holder == '0) || (holder == id_q);
			end
			ST_PROBE: begin
				mem_re    = cand_in;
				mem_raddr = cand_addr;
			end
			ST_PCHK: begin
				mem_we    = (holder == '0);
				mem_waddr = cand_q_addr;
			end
			default: mem_we = 1'b0;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	assign rsp.valid           = ov_q;
	assign rsp.collided        = o_collided_q;
	assign rsp.other_drone     = o_other_q;
	assign rsp.relocated       = o_relocated_q;
	assign rsp.placed_x        = o_px_q;
	assign rsp.placed_y        = o_py_q;
	assign rsp.placed_z        = o_pz_q;
	assign rsp.collision_total = o_total_q;
	assign rsp.aborted         = o_aborted_q;
	assign rsp.out_of_range    = o_oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			sweep_q       <= '0;
			sweep_rsp_q   <= 1'b0;
			epoch_q       <= '0;
			limit_q       <= LIMIT_RST;
			count_q       <= '0;
			abort_q       <= 1'b0;
			rx_q          <= '0;
			ry_q          <= '0;
			rz_q          <= '0;
			id_q          <= '0;
			dir_q         <= DIR_PX;
			r_q           <= '0;
			cx_q          <= '0;
			cy_q          <= '0;
			cz_q          <= '0;
			collided_q    <= 1'b0;
			relocated_q   <= 1'b0;
			oor_q         <= 1'b0;
			other_q       <= '0;
			px_q          <= '0;
			py_q          <= '0;
			pz_q          <= '0;
			ov_q          <= 1'b0;
			o_collided_q  <= 1'b0;
			o_relocated_q <= 1'b0;
			o_oor_q       <= 1'b0;
			o_aborted_q   <= 1'b0;
			o_other_q     <= '0;
			o_px_q        <= '0;
			o_py_q        <= '0;
			o_pz_q        <= '0;
			o_total_q     <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (ov_q && rsp.ready && (state_q != ST_FINISH)) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						rx_q        <= req.pos_x;
						ry_q        <= req.pos_y;
						rz_q        <= req.pos_z;
						id_q        <= ID_BITS'(req.drone_id);
						collided_q  <= 1'b0;
						relocated_q <= 1'b0;
						oor_q       <= 1'b0;
						other_q     <= '0;
						px_q        <= (req.func == FUNC_FRAME) ? '0 : req.pos_x;
						py_q        <= (req.func == FUNC_FRAME) ? '0 : req.pos_y;
						pz_q        <= (req.func == FUNC_FRAME) ? '0 : req.pos_z;
						if (req.func == FUNC_FRAME) begin
							epoch_q <= epoch_inc;
							if (epoch_inc == '0) begin
								sweep_q     <= '0;
								sweep_rsp_q <= 1'b1;
								state_q     <= ST_SWEEP;
							end else begin
								state_q <= ST_FINISH;
							end
						end else if (abort_q) begin
							state_q <= ST_FINISH;
						end else if (req_oor) begin
							oor_q   <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_LOOKUP;
						end
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == '1) begin
						state_q <= sweep_rsp_q ? ST_FINISH : ST_IDLE;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if ((holder != '0) && (holder != id_q)) begin
						collided_q <= 1'b1;
						other_q    <= ID_W'(holder);
						count_q    <= count_inc;
						if (count_inc >= limit_q) begin
							abort_q <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							r_q     <= RW'(1);
							dir_q   <= DIR_PX;
							state_q <= ST_PROBE;
						end
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_PROBE: begin
					cx_q <= cx;
					cy_q <= cy;
					cz_q <= cz;
					if (cand_in) begin
						state_q <= ST_PCHK;
					end else if (last_probe) begin
						state_q <= ST_FINISH;
					end else if (dir_q == DIR_NZ) begin
						dir_q <= DIR_PX;
						r_q   <= r_q + RW'(1);
					end else begin
						dir_q <= dir_q + 3'd1;
					end
				end
				ST_PCHK: begin
					if (holder == '0) begin
						relocated_q <= 1'b1;
						px_q        <= cx_q[POS_W-1:0];
						py_q        <= cy_q[POS_W-1:0];
						pz_q        <= cz_q[POS_W-1:0];
						state_q     <= ST_FINISH;
					end else if (last_probe) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_PROBE;
						if (dir_q == DIR_NZ) begin
							dir_q <= DIR_PX;
							r_q   <= r_q + RW'(1);
						end else begin
							dir_q <= dir_q + 3'd1;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						ov_q          <= 1'b1;
						o_collided_q  <= collided_q;
						o_relocated_q <= relocated_q;
						o_oor_q       <= oor_q;
						o_aborted_q   <= abort_q;
						o_other_q     <= other_q;
						o_px_q        <= px_q;
						o_py_q        <= py_q;
						o_pz_q        <= pz_q;
						o_total_q     <= count_q;
						sweep_rsp_q   <= 1'b0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[tb/tb_voxel_collision_relocator.sv]
// Testbench for voxel_collision_relocator: directed, random words checked vs table or predictor.
module tb_voxel_collision_relocator import vcr_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GX = GRID_X_DEF;
	localparam int GY = GRID_Y_DEF;
	localparam int GZ = GRID_Z_DEF;
	localparam int MAX_DIM = (GX > GY) ? ((GX > GZ) ? GX : GZ) : ((GY > GZ) ? GY : GZ);
	localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << ID_BITS_DEF) - 1);

	typedef enum int {PROBE_XP, PROBE_XN, PROBE_YP, PROBE_YN, PROBE_ZP, PROBE_ZN} probe_dir_t;

	typedef struct packed {
		logic             func;
		logic [ID_W-1:0]  drone_id;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_z;
	} place_req_t;

	typedef struct packed {
		logic             collided;
		logic [ID_W-1:0]  other_drone;
		logic             relocated;
		logic [POS_W-1:0] placed_x;
		logic [POS_W-1:0] placed_y;
		logic [POS_W-1:0] placed_z;
		logic [CNT_W-1:0] collision_total;
		logic             aborted;
		logic             out_of_range;
	} place_rsp_t;

	typedef struct {
		place_req_t word;
		bit         known;
		place_rsp_t typed;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_data;

	vcr_req_if req_ch();
	vcr_rsp_if rsp_ch();

	voxel_collision_relocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// predictor state
	logic [ID_W-1:0]  owner_grid [GX*GY*GZ];
	logic [CNT_W-1:0] collision_cnt;
	logic             abort_latched;
	logic [CNT_W-1:0] limit_reg;

	place_rsp_t pending_results[$];
	int         fault_count = 0;
	int         words_sent = 0;
	int         crowd_runs = 0;
	bit         tx_calm = 1'b0;
	bit         rx_calm = 1'b0;
	int         rx_hold = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic bit in_grid(input int x, input int y, input int z);
		return x >= 0 && x < GX && y >= 0 && y < GY && z >= 0 && z < GZ;
	endfunction

	function automatic int grid_slot(input int x, input int y, input int z);
		return (x * GY + y) * GZ + z;
	endfunction

	function automatic void probe_target(input int rx, input int ry, input int rz, input int d,
		input probe_dir_t s, output int x, output int y, output int z);
		x = rx;
		y = ry;
		z = rz;
		case (s)
			PROBE_XP: x = rx + d;
			PROBE_XN: x = rx - d;
			PROBE_YP: y = ry + d;
			PROBE_YN: y = ry - d;
			PROBE_ZP: z = rz + d;
			default:  z = rz - d;
		endcase
	endfunction

	function automatic place_rsp_t predict_placement(input place_req_t w);
		place_rsp_t      r;
		logic [ID_W-1:0] id;
		logic [ID_W-1:0] holder;
		int              rx, ry, rz, cx, cy, cz;
		id = w.drone_id & ID_MASK;
		rx = int'(w.pos_x);
		ry = int'(w.pos_y);
		rz = int'(w.pos_z);
		r = '0;
		r.placed_x = w.pos_x;
		r.placed_y = w.pos_y;
		r.placed_z = w.pos_z;
		if (w.func == FUNC_FRAME) begin
			foreach (owner_grid[i]) owner_grid[i] = '0;
			r.placed_x = '0;
			r.placed_y = '0;
			r.placed_z = '0;
		end else if (!abort_latched) begin
			if (!in_grid(rx, ry, rz)) begin
				r.out_of_range = 1'b1;
			end else begin
				holder = owner_grid[grid_slot(rx, ry, rz)];
				if (holder != '0 && holder != id) begin
					r.collided = 1'b1;
					r.other_drone = holder;
					if (collision_cnt != '1) collision_cnt++;
					if (collision_cnt >= limit_reg) begin
						abort_latched = 1'b1;
					end else begin
						for (int d = 1; d < MAX_DIM && !r.relocated; d++) begin
							for (int s = PROBE_XP; s <= PROBE_ZN && !r.relocated; s++) begin
								probe_target(rx, ry, rz, d, probe_dir_t'(s), cx, cy, cz);
								if (in_grid(cx, cy, cz) && owner_grid[grid_slot(cx, cy, cz)] == '0) begin
									owner_grid[grid_slot(cx, cy, cz)] = id;
									r.relocated = 1'b1;
									r.placed_x = POS_W'(cx);
									r.placed_y = POS_W'(cy);
									r.placed_z = POS_W'(cz);
								end
							end
						end
					end
				end else begin
					owner_grid[grid_slot(rx, ry, rz)] = id;
				end
			end
		end
		r.collision_total = collision_cnt;
		r.aborted = abort_latched;
		return r;
	endfunction

	function automatic string rsp_text(input place_rsp_t r);
		return $sformatf("col=%0d oth=%0d rel=%0d pos=(%0d,%0d,%0d) tot=%0d abt=%0d oor=%0d",
			r.collided, r.other_drone, r.relocated, r.placed_x, r.placed_y, r.placed_z,
			r.collision_total, r.aborted, r.out_of_range);
	endfunction

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10) $display("ERROR: %s", msg);
	endfunction

	function automatic dir_row_t mk_row(input bit known, input logic f, input logic [ID_W-1:0] id,
		input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
		dir_row_t row;
		row.word = '{func: f, drone_id: id, pos_x: x, pos_y: y, pos_z: z};
		row.known = known;
		row.typed = '0;
		if (f == FUNC_PLACE) begin
			row.typed.placed_x = x;
			row.typed.placed_y = y;
			row.typed.placed_z = z;
		end
		return row;
	endfunction

	function automatic int pick_gap();
		int pick;
		if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
		if (tx_calm) return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [POS_W-1:0] edge_coord();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) return '0;
		if (pick < 40) return '1;
		return POS_W'($urandom);
	endfunction

	function automatic logic [POS_W-1:0] jitter(input logic [POS_W-1:0] c);
		return c + POS_W'($urandom_range(0, 2)) - POS_W'(1);
	endfunction

	task automatic send_word(input place_req_t w, input bit known, input place_rsp_t typed);
		place_rsp_t p;
		int         gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid    <= 1'b1;
		req_ch.func     <= w.func;
		req_ch.drone_id <= w.drone_id;
		req_ch.pos_x    <= w.pos_x;
		req_ch.pos_y    <= w.pos_y;
		req_ch.pos_z    <= w.pos_z;
		do @(posedge clk); while (!req_ch.ready);
		p = predict_placement(w);
		pending_results.push_back(known ? typed : p);
		words_sent++;
	endtask

	task automatic send_place(input logic f, input logic [ID_W-1:0] id,
		input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
		send_word('{func: f, drone_id: id, pos_x: x, pos_y: y, pos_z: z}, 1'b0, '0);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		for (int c = 0; c < 400000 && pending_results.size() != 0; c++) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CNT_W-1:0] v);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
		limit_reg = v;
	endtask

	// burst of placements around one spot, small ID pool so cells collide
	task automatic cluster_burst();
		logic [POS_W-1:0] cx, cy, cz;
		logic [ID_W-1:0]  id;
		cx = edge_coord();
		cy = edge_coord();
		cz = edge_coord();
		repeat ($urandom_range(4, 12)) begin
			id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(1, 6));
			send_place(FUNC_PLACE, id, jitter(cx), jitter(cy), jitter(cz));
		end
	endtask

	// fill every cell on the three axes through a spot, then collide there: no free cell
	task automatic crowd_fill();
		logic [POS_W-1:0] cx, cy, cz;
		logic [ID_W-1:0]  first_id;
		int               x, y, z;
		cx = edge_coord();
		cy = edge_coord();
		cz = edge_coord();
		crowd_runs++;
		send_place(FUNC_FRAME, '0, '0, '0, '0);
		for (int d = 1; d < MAX_DIM; d++) begin
			for (int s = PROBE_XP; s <= PROBE_ZN; s++) begin
				probe_target(int'(cx), int'(cy), int'(cz), d, probe_dir_t'(s), x, y, z);
				if (in_grid(x, y, z))
					send_place(FUNC_PLACE, ID_W'($urandom_range(1, 255)), POS_W'(x), POS_W'(y),
						POS_W'(z));
			end
		end
		first_id = ID_W'($urandom_range(2, 255));
		send_place(FUNC_PLACE, first_id, cx, cy, cz);
		send_place(FUNC_PLACE, ID_W'($urandom_range(1, first_id - 1)), cx, cy, cz);
	endtask

	task automatic random_block(input int quota);
		int target;
		int pick;
		target = words_sent + quota;
		while (words_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_place(FUNC_FRAME, ID_W'($urandom), POS_W'($urandom), POS_W'($urandom),
					POS_W'($urandom));
			end else if (pick < 56) begin
				cluster_burst();
			end else if (pick < 59 && crowd_runs < 3 && !abort_latched) begin
				crowd_fill();
			end else if (pick < 62) begin
				wait_idle();
			end else begin
				send_place(($urandom_range(0, 9) == 0) ? FUNC_FRAME : FUNC_PLACE, ID_W'($urandom),
					POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
			end
		end
	endtask

	always @(negedge clk) begin
		int pick;
		if (rx_hold > 0) begin
			rsp_ch.ready <= 1'b0;
			rx_hold--;
		end else begin
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
			if (!rx_calm) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) rx_hold = $urandom_range(1, 3);
				else if (pick < 18) rx_hold = $urandom_range(15, 60);
			end
		end
	end

	always @(posedge clk) begin
		place_rsp_t got;
		place_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.collided        = rsp_ch.collided;
			got.other_drone     = rsp_ch.other_drone;
			got.relocated       = rsp_ch.relocated;
			got.placed_x        = rsp_ch.placed_x;
			got.placed_y        = rsp_ch.placed_y;
			got.placed_z        = rsp_ch.placed_z;
			got.collision_total = rsp_ch.collision_total;
			got.aborted         = rsp_ch.aborted;
			got.out_of_range    = rsp_ch.out_of_range;
			if (pending_results.size() == 0) begin
				note_fault({"unexpected word: ", rsp_text(got)});
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					note_fault($sformatf("mismatch: expected %s, got %s", rsp_text(want),
						rsp_text(got)));
			end
		end
	end

	initial begin
		dir_row_t rows[$];
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_data        = '0;
		req_ch.valid    = 1'b0;
		req_ch.func     = FUNC_FRAME;
		req_ch.drone_id = '0;
		req_ch.pos_x    = '0;
		req_ch.pos_y    = '0;
		req_ch.pos_z    = '0;
		foreach (owner_grid[i]) owner_grid[i] = '0;
		collision_cnt = '0;
		abort_latched = 1'b0;
		limit_reg     = LIMIT_RST;

		rows.push_back(mk_row(1, FUNC_FRAME, 8'd0, 4'd0, 4'd0, 4'd0));
		rows.push_back(mk_row(1, FUNC_PLACE, 8'd1, 4'd0, 4'd0, 4'd0));
		rows.push_back(mk_row(1, FUNC_PLACE, 8'd255, 4'd15, 4'd15, 4'd15));
		rows.push_back(mk_row(1, FUNC_PLACE, 8'd1, 4'd0, 4'd0, 4'd0));
		rows.push_back(mk_row(1, FUNC_PLACE, 8'd0, 4'd5, 4'd5, 4'd5));
		rows.push_back(mk_row(1, FUNC_PLACE, 8'd6, 4'd5, 4'd5, 4'd5));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd2, 4'd0, 4'd0, 4'd0));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd3, 4'd15, 4'd15, 4'd15));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd4, 4'd1, 4'd0, 4'd0));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd0, 4'd5, 4'd5, 4'd5));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'hAA, 4'd10, 4'd5, 4'd0));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'h55, 4'd5, 4'd10, 4'd15));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd7, 4'd8, 4'd8, 4'd8));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd8, 4'd9, 4'd8, 4'd8));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd9, 4'd7, 4'd8, 4'd8));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd10, 4'd8, 4'd8, 4'd8));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd11, 4'd0, 4'd15, 4'd0));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd12, 4'd0, 4'd15, 4'd0));
		rows.push_back(mk_row(0, FUNC_FRAME, 8'hFF, 4'd15, 4'd15, 4'd15));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'd13, 4'd0, 4'd0, 4'd0));
		rows.push_back(mk_row(0, FUNC_PLACE, 8'h80, 4'd15, 4'd0, 4'd15));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) send_word(rows[i].word, rows[i].known, rows[i].typed);

		wait_idle();
		write_limit(16'hFFFF);
		random_block(380);
		wait_idle();
		write_limit(16'd30000);
		random_block(380);
		// limit of one: next collision aborts, later placements are ignored
		wait_idle();
		write_limit(16'd1);
		random_block(80);

		wait_idle();
		repeat (200) @(posedge clk);
		if (pending_results.size() != 0)
			note_fault($sformatf("%0d words never arrived", pending_results.size()));
		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

[voxel_collision_relocator.f]
rtl/vcr_pkg.sv
rtl/vcr_if.sv
rtl/vcr_ram.sv
rtl/voxel_collision_relocator.sv
tb/tb_voxel_collision_relocator.sv
